// ===== sv/cmysed_pkg.sv =====
package cmysed_pkg;

  // Image and error geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int CHANNELS   = 3;
  localparam int ERROR_BITS = 12;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int BANK_DEPTH = MAX_WIDTH / 2;
  localparam int BANK_AW    = COL_W - 1;
  localparam int ERR_W      = ERROR_BITS;
  localparam int VAL_W      = ERROR_BITS + 2;
  localparam int PROD_W     = VAL_W + 3;
  localparam int LINE_W     = CHANNELS * ERR_W;
  localparam int PIX_W      = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int IMG_W_W    = 11;
  localparam int THR_W      = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH = 2'd0,
    CFG_THRESHOLD   = 2'd1,
    CFG_SERPENTINE  = 2'd2
  } cfg_idx_t;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = IMG_W_W'(512);
  localparam logic [THR_W-1:0]   THRESHOLD_RST   = THR_W'(128);
  localparam logic               SERPENTINE_RST  = 1'b1;

  localparam logic signed [VAL_W-1:0] FULL_SCALE = VAL_W'(255);

  // Per-pixel control seen by every channel slice
  typedef struct packed {
    logic fire;
    logic frame_start;
    logic first_row;
    logic last;
  } chan_ctl_t;

  // Divide by 16, truncating toward zero
  function automatic logic signed [VAL_W-1:0] div16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p[PROD_W-1] ? (p + PROD_W'(15)) : p;
    return VAL_W'(adj >>> 4);
  endfunction

  // Saturate to a signed ERR_W-bit error
  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [VAL_W:0] v);
    logic signed [VAL_W:0] hi;
    logic signed [VAL_W:0] lo;
    hi = (VAL_W+1)'((2 ** (ERR_W - 1)) - 1);
    lo = -hi - (VAL_W+1)'(1);
    if (v > hi) begin
      return ERR_W'(hi);
    end else if (v < lo) begin
      return ERR_W'(lo);
    end
    return ERR_W'(v);
  endfunction

endpackage

// ===== sv/cmy_serpentine_error_diffusion_unit.sv =====
// An input transfer passes the stage register, then the result register.
// Throughput: one pixel per clock while out_stall and the post-reset clear allow it;
// it is limited by the line buffer, which is read once and written up to twice
// per pixel across two column-parity RAM banks.
// Reset (synchronous, active low) restores the register defaults and row state,
// then zeroes all MAX_WIDTH/2 = 512 entries of each bank; in_stall is held
// high during that pass while configuration writes are still taken.
module cmy_serpentine_error_diffusion_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_frame_start,
  input  logic [cmysed_pkg::PIX_W-1:0]        in_red,
  input  logic [cmysed_pkg::PIX_W-1:0]        in_green,
  input  logic [cmysed_pkg::PIX_W-1:0]        in_blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_red_on,
  output logic                                out_green_on,
  output logic                                out_blue_on,
  output logic                                out_row_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cmysed_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cmysed_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int COL_W  = cmysed_pkg::COL_W;
  localparam int ERR_W  = cmysed_pkg::ERR_W;
  localparam int LINE_W = cmysed_pkg::LINE_W;
  localparam int PIX_W  = cmysed_pkg::PIX_W;

  typedef struct packed {
    logic                frame_start;
    logic                first_row;
    logic                last;
    logic                has_back;
    logic [COL_W-1:0]    x;
    logic [COL_W-1:0]    back;
    logic [PIX_W-1:0]    red;
    logic [PIX_W-1:0]    green;
    logic [PIX_W-1:0]    blue;
  } stage_t;

  // Configuration
  logic [cmysed_pkg::IMG_W_W-1:0] image_width_r;
  logic [cmysed_pkg::THR_W-1:0]   threshold_r;
  logic                           serpentine_r;

  // Scan position, advanced on input transfer
  logic [COL_W-1:0] col_r;
  logic             row_odd_r;
  logic             first_row_r;

  logic                          clearing_r;
  logic [cmysed_pkg::BANK_AW-1:0] clr_r;

  stage_t            s1_r, front;
  logic              s1_valid_r;
  logic              fwd_valid_r;
  logic [LINE_W-1:0] fwd_data_r;

  logic              out_valid_r, out_red_r, out_green_r, out_blue_r, out_row_end_r;

  logic                 in_acc, s1_fire;
  logic [COL_W:0]       w_clamp;
  logic [COL_W-1:0]     w_m1, cnt_base, cnt;
  logic                 odd_use, first_use, rev;

  logic [LINE_W-1:0] back_line, x_line, below_line;
  logic [LINE_W-1:0] rd0, rd1;
  logic              wr_back, wr_x, hit_back, hit_x;
  logic [2:0]        on_bits;
  cmysed_pkg::chan_ctl_t ctl;

  logic                           we0, we1;
  logic [cmysed_pkg::BANK_AW-1:0] wa0, wa1;
  logic [LINE_W-1:0]              wd0, wd1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= cmysed_pkg::IMAGE_WIDTH_RST;
      threshold_r   <= cmysed_pkg::THRESHOLD_RST;
      serpentine_r  <= cmysed_pkg::SERPENTINE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cmysed_pkg::CFG_IMAGE_WIDTH: image_width_r <= cfg_data[cmysed_pkg::IMG_W_W-1:0];
        cmysed_pkg::CFG_THRESHOLD:   threshold_r   <= cfg_data[cmysed_pkg::THR_W-1:0];
        cmysed_pkg::CFG_SERPENTINE:  serpentine_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign s1_fire  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_valid_r && !s1_fire);
  assign in_acc   = in_valid && !in_stall;

  // Front end: position of the incoming pixel
  always_comb begin
    if (image_width_r == '0) begin
      w_clamp = (COL_W+1)'(1);
    end else if (int'(image_width_r) > cmysed_pkg::MAX_WIDTH) begin
      w_clamp = (COL_W+1)'(cmysed_pkg::MAX_WIDTH);
    end else begin
      w_clamp = (COL_W+1)'(image_width_r);
    end
  end

  assign w_m1      = COL_W'(w_clamp - 1'b1);
  assign cnt_base  = in_frame_start ? '0 : col_r;
  assign odd_use   = in_frame_start ? 1'b0 : row_odd_r;
  assign first_use = in_frame_start ? 1'b1 : first_row_r;
  assign cnt       = (cnt_base > w_m1) ? w_m1 : cnt_base;
  assign rev       = serpentine_r && odd_use;

  always_comb begin
    front.frame_start = in_frame_start;
    front.first_row   = first_use;
    front.last        = (cnt == w_m1);
    front.has_back    = (cnt != '0);
    front.x           = rev ? (w_m1 - cnt) : cnt;
    front.back        = rev ? (front.x + 1'b1) : (front.x - 1'b1);
    front.red         = in_red;
    front.green       = in_green;
    front.blue        = in_blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_odd_r   <= 1'b0;
      first_row_r <= 1'b1;
    end else if (in_acc) begin
      if (front.last) begin
        col_r       <= '0;
        row_odd_r   <= ~odd_use;
        first_row_r <= 1'b0;
      end else begin
        col_r       <= cnt + 1'b1;
        row_odd_r   <= odd_use;
        first_row_r <= first_use;
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r        <= front;
      fwd_valid_r <= hit_back || hit_x;
      fwd_data_r  <= hit_back ? back_line : x_line;
    end
  end

  // Line-buffer writes of the pixel leaving the stage
  assign wr_back  = s1_fire && s1_r.has_back;
  assign wr_x     = s1_fire && s1_r.last;
  // Forward a write that lands on the column being read in the same cycle
  assign hit_back = wr_back && (s1_r.back == front.x);
  assign hit_x    = wr_x && (s1_r.x == front.x);

  assign below_line = fwd_valid_r ? fwd_data_r : (s1_r.x[0] ? rd1 : rd0);

  assign ctl.fire        = s1_fire;
  assign ctl.frame_start = s1_r.frame_start;
  assign ctl.first_row   = s1_r.first_row;
  assign ctl.last        = s1_r.last;

  for (genvar ch = 0; ch < cmysed_pkg::CHANNELS; ch++) begin : g_chan
    logic [PIX_W-1:0] pix;
    assign pix = (ch == 0) ? s1_r.red : ((ch == 1) ? s1_r.green : s1_r.blue);

    cmysed_chan u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .pix       (pix),
      .below_raw (below_line[ch*ERR_W +: ERR_W]),
      .thr       (threshold_r),
      .pix_on    (on_bits[ch]),
      .back_err  (back_line[ch*ERR_W +: ERR_W]),
      .x_err     (x_line[ch*ERR_W +: ERR_W])
    );
  end

  // Bank select by column parity; back and x are adjacent, so never the same bank
  always_comb begin
    we0 = clearing_r || (wr_back && !s1_r.back[0]) || (wr_x && !s1_r.x[0]);
    we1 = clearing_r || (wr_back && s1_r.back[0]) || (wr_x && s1_r.x[0]);
    priority if (clearing_r) begin
      wa0 = clr_r;
      wd0 = '0;
      wa1 = clr_r;
      wd1 = '0;
    end else begin
      wa0 = (wr_back && !s1_r.back[0]) ? s1_r.back[COL_W-1:1] : s1_r.x[COL_W-1:1];
      wd0 = (wr_back && !s1_r.back[0]) ? back_line : x_line;
      wa1 = (wr_back && s1_r.back[0]) ? s1_r.back[COL_W-1:1] : s1_r.x[COL_W-1:1];
      wd1 = (wr_back && s1_r.back[0]) ? back_line : x_line;
    end
  end

  cmysed_ram #(
    .WIDTH (LINE_W),
    .DEPTH (cmysed_pkg::BANK_DEPTH)
  ) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (wa0),
    .wdata (wd0),
    .re    (in_acc),
    .raddr (front.x[COL_W-1:1]),
    .rdata (rd0)
  );

  cmysed_ram #(
    .WIDTH (LINE_W),
    .DEPTH (cmysed_pkg::BANK_DEPTH)
  ) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (wa1),
    .wdata (wd1),
    .re    (in_acc),
    .raddr (front.x[COL_W-1:1]),
    .rdata (rd1)
  );

  // Zero the line buffer after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_red_r     <= on_bits[0];
      out_green_r   <= on_bits[1];
      out_blue_r    <= on_bits[2];
      out_row_end_r <= s1_r.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_red_on   = out_red_r;
  assign out_green_on = out_green_r;
  assign out_blue_on  = out_blue_r;
  assign out_row_end  = out_row_end_r;

endmodule

// ===== sv/cmysed_ram.sv =====
module cmysed_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/cmysed_chan.sv =====
module cmysed_chan (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cmysed_pkg::chan_ctl_t                 ctl,
  input  logic [cmysed_pkg::PIX_W-1:0]          pix,
  input  logic signed [cmysed_pkg::ERR_W-1:0]   below_raw,
  input  logic [cmysed_pkg::THR_W-1:0]          thr,
  output logic                                  pix_on,
  output logic signed [cmysed_pkg::ERR_W-1:0]   back_err,
  output logic signed [cmysed_pkg::ERR_W-1:0]   x_err
);

  logic signed [cmysed_pkg::ERR_W-1:0]  ahead_r, ahead_nxt;
  logic signed [cmysed_pkg::ERR_W-1:0]  pend_r, pend_nxt;
  logic signed [cmysed_pkg::ERR_W-1:0]  corner_r, corner_nxt;
  logic signed [cmysed_pkg::ERR_W-1:0]  ahead_use, pend_use, corner_use, below_use;
  logic signed [cmysed_pkg::VAL_W-1:0]  cmy, val, err;
  logic                                 quant;
  logic signed [cmysed_pkg::PROD_W-1:0] ee, p7, p3, p5;
  logic signed [cmysed_pkg::VAL_W-1:0]  s7, s3, s5, s1;

  // A frame start drops whatever the row registers carried
  assign ahead_use  = ctl.frame_start ? '0 : ahead_r;
  assign pend_use   = ctl.frame_start ? '0 : pend_r;
  assign corner_use = ctl.frame_start ? '0 : corner_r;
  assign below_use  = ctl.first_row ? '0 : below_raw;

  // Invert the 8-bit component before widening so the upper bits stay zero
  assign cmy   = $signed({{(cmysed_pkg::VAL_W - cmysed_pkg::PIX_W){1'b0}}, ~pix});
  assign val   = cmy + cmysed_pkg::VAL_W'(below_use) + cmysed_pkg::VAL_W'(ahead_use);
  assign quant = val >= $signed(cmysed_pkg::VAL_W'(thr));
  assign err   = quant ? (val - cmysed_pkg::FULL_SCALE) : val;

  assign ee = cmysed_pkg::PROD_W'(err);
  assign p7 = (ee <<< 3) - ee;
  assign p3 = (ee <<< 1) + ee;
  assign p5 = (ee <<< 2) + ee;

  assign s7 = cmysed_pkg::div16(p7);
  assign s3 = cmysed_pkg::div16(p3);
  assign s5 = cmysed_pkg::div16(p5);
  assign s1 = cmysed_pkg::div16(ee);

  assign ahead_nxt  = cmysed_pkg::sat_err((cmysed_pkg::VAL_W+1)'(s7));
  assign pend_nxt   = cmysed_pkg::sat_err((cmysed_pkg::VAL_W+1)'(corner_use)
                                          + (cmysed_pkg::VAL_W+1)'(s5));
  assign corner_nxt = cmysed_pkg::sat_err((cmysed_pkg::VAL_W+1)'(s1));

  assign back_err = cmysed_pkg::sat_err((cmysed_pkg::VAL_W+1)'(pend_use)
                                        + (cmysed_pkg::VAL_W+1)'(s3));
  assign x_err    = pend_nxt;
  assign pix_on   = ~quant;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ahead_r  <= '0;
      pend_r   <= '0;
      corner_r <= '0;
    end else if (ctl.fire) begin
      if (ctl.last) begin
        ahead_r  <= '0;
        pend_r   <= '0;
        corner_r <= '0;
      end else begin
        ahead_r  <= ahead_nxt;
        pend_r   <= pend_nxt;
        corner_r <= corner_nxt;
      end
    end
  end

endmodule
